@@ hdl/riv_pkg.sv @@
// ----------------------------------------------------------------------------
// riv_pkg
// Shared constants, the request mode codes and the per-cell command struct for
// the rank indexed vector core.
// ----------------------------------------------------------------------------
package riv_pkg;

    localparam int CAPACITY      = 16;
    localparam int DATA_WIDTH    = 32;
    localparam int RANK_W        = 5;
    localparam int VALUE_W       = 32;
    localparam int COUNT_FIELD_W = 5;
    localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);
    localparam int CMP_W         = (COUNT_W > RANK_W) ? COUNT_W : RANK_W;

    typedef enum logic [1:0] {
        MODE_GET     = 2'd0,
        MODE_REPLACE = 2'd1,
        MODE_INSERT  = 2'd2,
        MODE_REMOVE  = 2'd3
    } mode_t;

    typedef struct packed {
        logic                  replace_en;
        logic                  insert_en;
        logic                  remove_en;
        logic [CMP_W-1:0]      rank;
        logic [DATA_WIDTH-1:0] value;
    } cell_cmd_t;

endpackage

@@ hdl/riv_req_if.sv @@
// ----------------------------------------------------------------------------
// riv_req_if
// Request channel: mode, rank and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface riv_req_if;

    logic         valid;
    logic         ready;
    logic [1:0]   mode;
    logic [4:0]   rank;
    logic [31:0]  value;

    modport source (output valid, output mode, output rank, output value, input ready);
    modport sink   (input valid, input mode, input rank, input value, output ready);

endinterface

@@ hdl/riv_rsp_if.sv @@
// ----------------------------------------------------------------------------
// riv_rsp_if
// Result channel: status, read data, count and empty flag with valid/ready.
// ----------------------------------------------------------------------------
interface riv_rsp_if;

    logic         valid;
    logic         ready;
    logic         ok;
    logic [31:0]  read_value;
    logic [4:0]   count;
    logic         empty_res;

    modport source (output valid, output ok, output read_value, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input ok, input read_value, input count,
                    input empty_res, output ready);

endinterface

@@ hdl/riv_cell.sv @@
// ----------------------------------------------------------------------------
// riv_cell
// One storage cell of the chain. It compares its own position with the rank
// of the broadcast command and loads the new value or a neighbor's entry.
// ----------------------------------------------------------------------------
module riv_cell
    import riv_pkg::*;
(
    input  logic                  clk,
    input  logic [CMP_W-1:0]      idx,
    input  cell_cmd_t             cmd,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  at_rank;
    logic                  above_rank;

    assign at_rank    = (idx == cmd.rank);
    assign above_rank = (idx > cmd.rank);

    always_comb
    begin
        data_next = data_reg;
        if ((cmd.replace_en || cmd.insert_en) && at_rank)
        begin
            data_next = cmd.value;
        end
        else if (cmd.insert_en && above_rank)
        begin
            data_next = left_data;
        end
        else if (cmd.remove_en && (at_rank || above_rank))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ hdl/rank_indexed_vector_core.sv @@
// ----------------------------------------------------------------------------
// rank_indexed_vector_core
// Fixed-capacity ordered list addressed by zero-based rank, built as a chain
// of storage cells that shift toward their neighbors on insert and remove.
// ----------------------------------------------------------------------------
// Usage: each request on req carries a mode (get, replace, insert, remove),
// a rank and a value. Every request gives exactly one result on rsp with an
// ok flag, the entry read by get or taken out by remove, the count after the
// request and an empty flag. A failed request leaves the store unchanged.
// The result is registered at the edge that accepts the request.
// Throughput is one request per cycle while the receiver takes each
// result; all cells compare their position with the rank and shift in the
// same cycle, so the next request sees the updated store at once.
// When the receiver stalls, the result holds in the output register and
// req.ready drops until it is taken; a request can enter in the same cycle
// that the waiting result leaves.
// Reset clears the count and the output valid; the entries themselves are not
// cleared and hold no meaning until written.
// ----------------------------------------------------------------------------
module rank_indexed_vector_core
    import riv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    riv_req_if.sink  req,
    riv_rsp_if.source rsp
);

    logic [COUNT_W-1:0]       fill_reg;
    logic [COUNT_W-1:0]       fill_next;
    logic                     rsp_valid_reg;
    logic                     ok_reg;
    logic [DATA_WIDTH-1:0]    rd_reg;
    logic [DATA_WIDTH-1:0]    rd_next;
    logic                     ok_next;
    logic                     accept;
    logic [CMP_W-1:0]         rank_ext;
    logic [CMP_W-1:0]         fill_ext;
    logic                     in_range;
    logic                     ins_room;
    logic [IDX_W-1:0]         rd_idx;
    mode_t                    mode;
    cell_cmd_t                cmd;
    logic [DATA_WIDTH-1:0]    cell_q [CAPACITY];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign mode      = mode_t'(req.mode);
    assign rank_ext  = CMP_W'(req.rank);
    assign fill_ext  = CMP_W'(fill_reg);
    assign in_range  = (rank_ext < fill_ext);
    assign ins_room  = (rank_ext <= fill_ext) && (fill_reg < COUNT_W'(CAPACITY));
    assign rd_idx    = rank_ext[IDX_W-1:0];

    always_comb
    begin
        ok_next   = 1'b0;
        rd_next   = '0;
        fill_next = fill_reg;
        cmd.replace_en = 1'b0;
        cmd.insert_en  = 1'b0;
        cmd.remove_en  = 1'b0;
        cmd.rank       = rank_ext;
        cmd.value      = req.value[DATA_WIDTH-1:0];
        case (mode)
            MODE_GET:
            begin
                ok_next = in_range;
                if (in_range)
                begin
                    rd_next = cell_q[rd_idx];
                end
            end
            MODE_REPLACE:
            begin
                ok_next        = in_range;
                cmd.replace_en = accept && in_range;
            end
            MODE_INSERT:
            begin
                ok_next       = ins_room;
                cmd.insert_en = accept && ins_room;
                if (ins_room)
                begin
                    fill_next = fill_reg + COUNT_W'(1);
                end
            end
            MODE_REMOVE:
            begin
                ok_next       = in_range;
                cmd.remove_en = accept && in_range;
                if (in_range)
                begin
                    rd_next   = cell_q[rd_idx];
                    fill_next = fill_reg - COUNT_W'(1);
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = cmd.value;
        end
        else
        begin : g_mid_left
            assign left_data = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_q[i];
        end
        else
        begin : g_mid_right
            assign right_data = cell_q[i+1];
        end

        riv_cell u_cell (
            .clk        (clk),
            .idx        (CMP_W'(i)),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg      <= fill_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg <= ok_next;
            rd_reg <= rd_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.read_value = VALUE_W'(rd_reg);
    assign rsp.count      = COUNT_FIELD_W'(fill_reg);
    assign rsp.empty_res  = (fill_reg == '0);

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= COUNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == MODE_INSERT) && ins_room |=> fill_reg == $past(fill_reg) + COUNT_W'(1))
        else $error("successful insert did not grow the count");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == MODE_REMOVE) && in_range |=> fill_reg == $past(fill_reg) - COUNT_W'(1))
        else $error("successful remove did not shrink the count");

    a_fail_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ok |-> rsp.read_value == '0)
        else $error("failed request returned read data");
`endif

endmodule
